// File: src/sleqw_pkg.sv
package sleqw_pkg;

   localparam int WL_W      = 32;
   localparam int FLUX_W    = 24;
   localparam int EW_W      = 40;
   localparam int AVG_LEN_W = 13;
   localparam int HALF_W    = 12;
   localparam int SUM_W     = 37;
   localparam int AVG_W     = 33;
   localparam int MD_A_W    = 46;
   localparam int MD_B_W    = 34;
   localparam int MD_C_W    = 64;
   localparam int ACC_X_W   = 66;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_EDGE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_EDGE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AVG_LEN   = 2'd2;

   localparam logic [AVG_LEN_W-1:0]     AVG_LEN_RESET = 13'd2;
   localparam logic signed [EW_W-1:0]   EW_NOT_FOUND  = -40'sd256;
   localparam logic signed [EW_W-1:0]   EW_HIGH       = 40'sh7F_FFFF_FFFF;
   localparam logic signed [EW_W-1:0]   EW_LOW        = 40'sh80_0000_0000;
   localparam logic [MD_C_W-1:0]        MD_CAP        = 64'h4000_0000_0000_0000;

   typedef enum logic [4:0] {
      ST_LOAD, ST_CHECK, ST_RD_WB, ST_RD_WR, ST_LATCH_WR, ST_SUM,
      ST_AVG0, ST_AVG0_W, ST_AVG1, ST_AVG1_W,
      ST_PT_RD0, ST_PT_RD1, ST_PT_RD2, ST_PT_C, ST_PT_CW, ST_PT_T, ST_PT_TW,
      ST_PT_NEXT, ST_DONE
   } state_type;

   typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV, MD_FIN} md_state_type;

   typedef struct packed {
      logic                     start;
      logic signed [MD_A_W-1:0] a;
      logic signed [MD_B_W-1:0] b;
      logic signed [MD_C_W-1:0] c;
   } md_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [MD_C_W-1:0] quo;
      logic                     rem_nz;
   } md_rsp_type;

endpackage

// File: src/sleqw_ram.sv
module sleqw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: src/sleqw_muldiv.sv
module sleqw_muldiv (
   input  logic                   clock,
   input  logic                   reset,
   input  sleqw_pkg::md_req_type  req,
   output sleqw_pkg::md_rsp_type  rsp
);
   import sleqw_pkg::*;

   md_state_type      st_ff, st_in;
   logic [MD_C_W-1:0] x_ff, prod_ff, z_ff, rem_ff;
   logic [MD_B_W-1:0] y_ff;
   logic [6:0]        cnt_ff;
   logic              neg_ff;

   logic [MD_A_W-1:0] amag;
   logic [MD_B_W-1:0] bmag;
   logic [MD_C_W-1:0] cmag, qcap;
   logic [MD_C_W:0]   rem_sh;
   logic              take;

   assign amag   = req.a[MD_A_W-1] ? MD_A_W'(-req.a) : MD_A_W'(req.a);
   assign bmag   = req.b[MD_B_W-1] ? MD_B_W'(-req.b) : MD_B_W'(req.b);
   assign cmag   = req.c[MD_C_W-1] ? MD_C_W'(-req.c) : MD_C_W'(req.c);
   assign rem_sh = {rem_ff, prod_ff[MD_C_W-1]};
   assign take   = rem_sh >= {1'b0, z_ff};
   assign qcap   = (prod_ff > MD_CAP) ? MD_CAP : prod_ff;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         MD_IDLE: if (req.start) st_in = MD_MUL;
         MD_MUL:  if (cnt_ff == 7'(MD_B_W - 1)) st_in = MD_DIV;
         MD_DIV:  if (cnt_ff == 7'(MD_C_W - 1)) st_in = MD_FIN;
         MD_FIN:  st_in = MD_IDLE;
         default: st_in = MD_IDLE;
      endcase
   end

   always_comb begin
      rsp.done   = (st_ff == MD_FIN);
      rsp.quo    = neg_ff ? -$signed(qcap) : $signed(qcap);
      rsp.rem_nz = (rem_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= MD_IDLE;
         cnt_ff <= '0;
      end else begin
         st_ff <= st_in;
         case (st_ff)
            MD_IDLE: begin
               cnt_ff <= '0;
               if (req.start) begin
                  x_ff    <= MD_C_W'(amag);
                  y_ff    <= bmag;
                  z_ff    <= cmag;
                  neg_ff  <= req.a[MD_A_W-1] ^ req.b[MD_B_W-1] ^ req.c[MD_C_W-1];
                  prod_ff <= '0;
                  rem_ff  <= '0;
               end
            end
            MD_MUL: begin
               if (y_ff[0]) prod_ff <= prod_ff + x_ff;
               x_ff   <= x_ff << 1;
               y_ff   <= y_ff >> 1;
               cnt_ff <= (cnt_ff == 7'(MD_B_W - 1)) ? '0 : cnt_ff + 7'd1;
            end
            MD_DIV: begin
               rem_ff  <= take ? MD_C_W'(rem_sh - {1'b0, z_ff}) : MD_C_W'(rem_sh);
               prod_ff <= {prod_ff[MD_C_W-2:0], take};
               cnt_ff  <= cnt_ff + 7'd1;
            end
            default: cnt_ff <= '0;
         endcase
      end
   end
endmodule

// File: src/spectral_line_equivalent_width_core.sv
// Equivalent width over a linear continuum, spectrum held in two sample RAMs.
// Loading: one sample transaction per cycle; the result register lets the next
// spectrum load while a result waits. After last_sample the finish pass sums
// the two continuum windows, forms their averages and integrates each sample,
// the averages and each integrated sample using the shared shift-add/restore
// multiply-divide unit. Reset (synchronous, active high) clears control only.
module spectral_line_equivalent_width_core #(
   parameter int MAX_SAMPLES = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [31:0]                       req_wavelength,
   input  logic signed [23:0]                req_flux_value,
   input  logic                              req_last_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [39:0]                rsp_line_width,
   output logic [31:0]                       rsp_blue_used,
   output logic [31:0]                       rsp_red_used,
   output logic                              rsp_status,
   input  logic                              csr_write_enable,
   input  logic [sleqw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                       csr_wdata
);
   import sleqw_pkg::*;

   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int NW = ((CW > 15) ? CW : 15) + 1;

   state_type st_ff, st_in;

   logic [WL_W-1:0]      blue_edge_ff, red_edge_ff;
   logic [AVG_LEN_W-1:0] avg_len_ff;
   logic [CW-1:0]        count_ff;
   logic [AW-1:0]        bidx_ff, ridx_ff, bic_ff, ric_ff, bs_ff, rs_ff, i_ff;
   logic [NW-1:0]        j_ff;
   logic                 pend_ff, sel_ff;
   logic signed [SUM_W-1:0]  s0_ff, s1_ff;
   logic signed [AVG_W-1:0]  a0_ff, a1_ff;
   logic [WL_W-1:0]      wb_ff, wr_ff, wli_ff, wlo_ff;
   logic signed [FLUX_W-1:0] fli_ff;
   logic signed [MD_B_W-1:0] d_ff;
   logic signed [MD_C_W-1:0] c_ff;
   logic signed [EW_W-1:0]   acc_ff;
   logic                 status_ff;

   logic                      rsp_valid_ff;
   logic signed [EW_W-1:0]    rsp_ew_ff;
   logic [WL_W-1:0]           rsp_blue_ff, rsp_red_ff;
   logic                      rsp_status_ff;

   logic                 accept, wr_en;
   logic [AW-1:0]        rd_addr;
   logic [WL_W-1:0]      wl_rdata;
   logic [FLUX_W-1:0]    fl_rdata;
   logic [HALF_W-1:0]    h;
   logic [NW-1:0]        hx, win, nx, bix, rix, bic_x, ric_x, t_b, t_r;
   logic                 not_found, issue, span_zero, out_free;
   logic signed [WL_W:0] span;
   logic signed [MD_B_W-1:0] d_calc;
   logic signed [ACC_X_W-1:0] acc_sum;
   md_req_type md_req;
   md_rsp_type md_rsp;

   assign accept   = req_valid && req_ready;
   assign wr_en    = accept && (count_ff < CW'(MAX_SAMPLES));
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign h   = (avg_len_ff[AVG_LEN_W-1:1] == '0) ? HALF_W'(1) : avg_len_ff[AVG_LEN_W-1:1];
   assign hx  = NW'(h);
   assign win = hx << 1;
   assign nx  = NW'(count_ff);
   assign bix = NW'(bidx_ff);
   assign rix = NW'(ridx_ff);
   assign not_found = (bidx_ff == '0) || (ridx_ff == '0) || (nx < win + NW'(1));
   assign t_b   = (bix < hx) ? hx : bix;
   assign bic_x = (t_b > nx - hx) ? nx - hx : t_b;
   assign t_r   = (rix > nx - hx - NW'(1)) ? nx - hx - NW'(1) : rix;
   assign ric_x = (t_r < hx) ? hx : t_r;

   assign issue     = j_ff < (win << 1);
   assign span      = $signed({1'b0, wr_ff}) - $signed({1'b0, wb_ff});
   assign span_zero = (span == '0);
   assign d_calc    = (i_ff == '0)
                      ? MD_B_W'($signed({1'b0, wlo_ff}) - $signed({1'b0, wli_ff}))
                      : MD_B_W'($signed({1'b0, wli_ff}) - $signed({1'b0, wlo_ff}));
   assign acc_sum   = ACC_X_W'(acc_ff) + ACC_X_W'(d_ff) - ACC_X_W'(md_rsp.quo);

   sleqw_ram #(.WIDTH(WL_W), .DEPTH(MAX_SAMPLES)) u_wl_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (count_ff[AW-1:0]),
      .wdata (req_wavelength),
      .raddr (rd_addr),
      .rdata (wl_rdata)
   );

   sleqw_ram #(.WIDTH(FLUX_W), .DEPTH(MAX_SAMPLES)) u_flux_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (count_ff[AW-1:0]),
      .wdata (req_flux_value),
      .raddr (rd_addr),
      .rdata (fl_rdata)
   );

   sleqw_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .req   (md_req),
      .rsp   (md_rsp)
   );

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_LOAD:     if (accept && req_last_sample) st_in = ST_CHECK;
         ST_CHECK:    st_in = not_found ? ST_DONE : ST_RD_WB;
         ST_RD_WB:    st_in = ST_RD_WR;
         ST_RD_WR:    st_in = ST_LATCH_WR;
         ST_LATCH_WR: st_in = ST_SUM;
         ST_SUM:      if (!issue && !pend_ff) st_in = ST_AVG0;
         ST_AVG0:     st_in = ST_AVG0_W;
         ST_AVG0_W:   if (md_rsp.done) st_in = ST_AVG1;
         ST_AVG1:     st_in = ST_AVG1_W;
         ST_AVG1_W:   if (md_rsp.done) st_in = (bs_ff > rs_ff) ? ST_DONE : ST_PT_RD0;
         ST_PT_RD0:   st_in = ST_PT_RD1;
         ST_PT_RD1:   st_in = ST_PT_RD2;
         ST_PT_RD2:   st_in = ST_PT_C;
         ST_PT_C:     st_in = span_zero ? ST_PT_T : ST_PT_CW;
         ST_PT_CW:    if (md_rsp.done) st_in = ST_PT_T;
         ST_PT_T:     st_in = (c_ff == '0) ? ST_PT_NEXT : ST_PT_TW;
         ST_PT_TW:    if (md_rsp.done) st_in = ST_PT_NEXT;
         ST_PT_NEXT:  st_in = (i_ff == rs_ff) ? ST_DONE : ST_PT_RD0;
         ST_DONE:     if (out_free) st_in = ST_LOAD;
         default:     st_in = ST_LOAD;
      endcase
   end

   always_comb begin
      req_ready    = (st_ff == ST_LOAD);
      rd_addr      = i_ff;
      md_req.start = 1'b0;
      md_req.a     = MD_A_W'(s0_ff);
      md_req.b     = MD_B_W'(256);
      md_req.c     = MD_C_W'(win);
      case (st_ff)
         ST_RD_WB: rd_addr = bic_ff;
         ST_RD_WR: rd_addr = ric_ff;
         ST_SUM:   rd_addr = (j_ff < win) ? AW'(NW'(bs_ff) + j_ff)
                                          : AW'(NW'(rs_ff) + j_ff - win);
         ST_PT_RD1: rd_addr = (i_ff == '0) ? AW'(1) : i_ff - AW'(1);
         ST_AVG0: md_req.start = 1'b1;
         ST_AVG1: begin
            md_req.start = 1'b1;
            md_req.a     = MD_A_W'(s1_ff);
         end
         ST_PT_C: begin
            md_req.start = !span_zero;
            md_req.a     = MD_A_W'(MD_B_W'(a1_ff) - MD_B_W'(a0_ff));
            md_req.b     = MD_B_W'($signed({1'b0, wli_ff}) - $signed({1'b0, wb_ff}));
            md_req.c     = MD_C_W'(span);
         end
         ST_PT_T: begin
            md_req.start = (c_ff != '0);
            md_req.a     = MD_A_W'($signed({fli_ff, 8'h00}));
            md_req.b     = d_ff;
            md_req.c     = c_ff;
         end
         default: rd_addr = i_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_LOAD;
         blue_edge_ff <= '0;
         red_edge_ff  <= '0;
         avg_len_ff   <= AVG_LEN_RESET;
         count_ff     <= '0;
         bidx_ff      <= '0;
         ridx_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BLUE_EDGE: blue_edge_ff <= csr_wdata;
               CSR_RED_EDGE:  red_edge_ff  <= csr_wdata;
               CSR_AVG_LEN:   avg_len_ff   <= csr_wdata[AVG_LEN_W-1:0];
               default:       ;
            endcase
         end
         if (wr_en) begin
            count_ff <= count_ff + CW'(1);
            if (bidx_ff == '0 && req_wavelength >= blue_edge_ff) bidx_ff <= count_ff[AW-1:0];
            if (ridx_ff == '0 && req_wavelength >= red_edge_ff)  ridx_ff <= count_ff[AW-1:0];
         end
         if (st_ff == ST_SUM) begin
            pend_ff <= issue;
         end else begin
            pend_ff <= 1'b0;
         end
         if (st_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
            count_ff     <= '0;
            bidx_ff      <= '0;
            ridx_ff      <= '0;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (st_ff)
         ST_CHECK: begin
            status_ff <= not_found;
            acc_ff    <= not_found ? EW_NOT_FOUND : '0;
            bic_ff    <= AW'(bic_x);
            ric_ff    <= AW'(ric_x);
            bs_ff     <= AW'(bic_x - hx);
            rs_ff     <= AW'(ric_x - hx);
            j_ff      <= '0;
            s0_ff     <= '0;
            s1_ff     <= '0;
         end
         ST_RD_WR:    wb_ff <= wl_rdata;
         ST_LATCH_WR: wr_ff <= wl_rdata;
         ST_SUM: begin
            if (issue) j_ff <= j_ff + NW'(1);
            sel_ff <= (j_ff >= win);
            if (pend_ff) begin
               if (sel_ff) s1_ff <= s1_ff + SUM_W'($signed(fl_rdata));
               else        s0_ff <= s0_ff + SUM_W'($signed(fl_rdata));
            end
         end
         ST_AVG0_W: if (md_rsp.done)
            a0_ff <= AVG_W'(md_rsp.quo - MD_C_W'(s0_ff[SUM_W-1] && md_rsp.rem_nz));
         ST_AVG1_W: if (md_rsp.done) begin
            a1_ff <= AVG_W'(md_rsp.quo - MD_C_W'(s1_ff[SUM_W-1] && md_rsp.rem_nz));
            i_ff  <= bs_ff;
         end
         ST_PT_RD1: begin
            wli_ff <= wl_rdata;
            fli_ff <= fl_rdata;
         end
         ST_PT_RD2: wlo_ff <= wl_rdata;
         ST_PT_C: begin
            d_ff <= d_calc;
            c_ff <= MD_C_W'(a0_ff);
         end
         ST_PT_CW: if (md_rsp.done) c_ff <= MD_C_W'(a0_ff) + md_rsp.quo;
         ST_PT_TW: if (md_rsp.done) begin
            if (acc_sum > ACC_X_W'(EW_HIGH))      acc_ff <= EW_HIGH;
            else if (acc_sum < ACC_X_W'(EW_LOW))  acc_ff <= EW_LOW;
            else                                  acc_ff <= EW_W'(acc_sum);
         end
         ST_PT_NEXT: i_ff <= i_ff + AW'(1);
         ST_DONE: if (out_free) begin
            rsp_ew_ff     <= acc_ff;
            rsp_blue_ff   <= status_ff ? blue_edge_ff : wb_ff;
            rsp_red_ff    <= status_ff ? red_edge_ff : wr_ff;
            rsp_status_ff <= status_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_line_width       = rsp_ew_ff;
   assign rsp_blue_used        = rsp_blue_ff;
   assign rsp_red_used         = rsp_red_ff;
   assign rsp_status           = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_SAMPLES)) else $error("sample count overflow");
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_sample |=> !req_ready) else $error("load continued after last");
   a_nf_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_line_width == EW_NOT_FOUND)
      else $error("not-found result value");
   a_md_start: assert property (@(posedge clock) disable iff (reset)
      md_req.start |=> !md_rsp.done) else $error("muldiv start overlap");
`endif
endmodule
